### rtl/core/iee_pkg.sv
// ---------------------------------------------------------------------------
// iee_pkg
// Shared types and constants of the infix expression evaluator.
// ---------------------------------------------------------------------------
package iee_pkg;

  localparam int STACK_DEPTH_DEF = 16;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int VALUE_WIDTH_DEF = 48;

  typedef enum logic [2:0] {
    OP_LP  = 3'd0,
    OP_ADD = 3'd1,
    OP_SUB = 3'd2,
    OP_MUL = 3'd3,
    OP_DIV = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_DIV0      = 2'd1,
    ST_MALFORMED = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_t;

  localparam logic [7:0] CH_LP    = 8'h28;
  localparam logic [7:0] CH_RP    = 8'h29;
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_ADD   = 8'h2B;
  localparam logic [7:0] CH_SUB   = 8'h2D;
  localparam logic [7:0] CH_DIV   = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TOKEN,
    S_RED_CHK,
    S_RED_POP,
    S_RED_EXEC,
    S_RED_WAIT,
    S_RED_DONE,
    S_PUSH_OP,
    S_FIN_CHK,
    S_RESULT,
    S_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic acc_digit;
    logic flush_num;
    logic push_op;
    logic pop_op;
    logic pop_opd;
    logic start_reduce;
    logic commit_reduce;
    logic load_result;
    logic clear_all;
    logic [1:0] raise;
    op_t  op_code;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic    busy;
    logic    opd_ge2;
    logic    opd_is1;
    logic    opr_empty;
    logic    opr_full;
    logic    opd_full;
    op_t     top_op;
    status_t err;
  } stat_t;

endpackage

### rtl/core/iee_if.sv
// ---------------------------------------------------------------------------
// iee_in_if / iee_out_if
// Valid/ready channels of the evaluator.
// ---------------------------------------------------------------------------
interface iee_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;
  modport source (output valid, char_code, last_char, input ready);
  modport sink   (input valid, char_code, last_char, output ready);
endinterface

interface iee_out_if #(parameter int VALUE_WIDTH = 48);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] value;
  logic [1:0]                    status;
  modport source (output valid, value, status, input ready);
  modport sink   (input valid, value, status, output ready);
endinterface

### rtl/core/infix_expression_evaluator_top.sv
// ---------------------------------------------------------------------------
// infix_expression_evaluator_top
// Two-stack infix evaluator: one character per word, one result per expression.
// ---------------------------------------------------------------------------
// Reductions by * and / run in the ALU's one-bit-a-cycle shift-add and restoring
// divide loop; reductions by + and - need no loop. The final word drains both
// stacks before the result; one word is taken at a time, and no new word is
// accepted until the last one has been handled.
// Synchronous active-low reset empties both stacks and returns the controller to idle.
module infix_expression_evaluator_top #(
  parameter int STACK_DEPTH = iee_pkg::STACK_DEPTH_DEF,
  parameter int FRAC_BITS   = iee_pkg::FRAC_BITS_DEF,
  parameter int VALUE_WIDTH = iee_pkg::VALUE_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  iee_in_if.sink    in_ch,
  iee_out_if.source out_ch
);
  import iee_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic [VALUE_WIDTH-1:0] result;
  logic [3:0] digit;

  iee_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_char(in_ch.char_code),
    .in_last(in_ch.last_char), .in_ready(in_ch.ready), .out_valid(out_ch.valid),
    .out_ready(out_ch.ready), .stat(stat), .cmd(cmd), .digit(digit)
  );

  iee_datapath #(.STACK_DEPTH(STACK_DEPTH), .FRAC_BITS(FRAC_BITS),
                 .VALUE_WIDTH(VALUE_WIDTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .digit(digit),
    .stat(stat), .result(result)
  );

  // The status latched with the result is held beside it.
  status_t st_out_r;
  always_ff @(posedge clk) begin
    if (cmd.load_result) st_out_r <= stat.err;
  end

  assign out_ch.value  = result;
  assign out_ch.status = st_out_r;

  a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !in_ch.ready) else $error("input taken while result pending");
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.value))
    else $error("pending result lost");
  a_alu_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    stat.busy |-> !in_ch.ready) else $error("input accepted during reduction");
endmodule

### rtl/core/iee_alu.sv
// ---------------------------------------------------------------------------
// iee_alu
// Multi-cycle arithmetic unit: add, subtract, multiply and restoring divide.
// ---------------------------------------------------------------------------
module iee_alu #(
  parameter int VALUE_WIDTH = 48,
  parameter int FRAC_BITS   = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  iee_pkg::op_t           op,
  input  logic [VALUE_WIDTH-1:0] a,
  input  logic [VALUE_WIDTH-1:0] b,
  output logic                   busy,
  output logic                   done,
  output logic [VALUE_WIDTH-1:0] res,
  output iee_pkg::status_t       err
);
  import iee_pkg::*;

  localparam int W  = VALUE_WIDTH;
  localparam int NW = W + FRAC_BITS;   // numerator / accumulator width
  localparam int CW = $clog2(NW + 1);

  logic          busy_r, busy_nxt, done_r, done_nxt;
  logic          neg_r, neg_nxt, mul_r, mul_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [NW-1:0] acc_r, acc_nxt;     // product or quotient
  logic [NW-1:0] num_r, num_nxt;     // multiplier / dividend shift
  logic [W:0]    rem_r, rem_nxt;
  logic [W-1:0]  mb_r, mb_nxt;
  logic [W-1:0]  res_r, res_nxt;
  status_t       err_r, err_nxt;

  logic [W-1:0] ma, mbv;
  logic [W:0]   sum, trial;
  logic [NW:0]  madd;
  logic [NW-1:0] lim;

  always_comb begin
    ma    = a[W-1] ? (~a + 1'b1) : a;
    mbv   = b[W-1] ? (~b + 1'b1) : b;
    sum   = (op == OP_ADD) ? ({a[W-1], a} + {b[W-1], b}) : ({a[W-1], a} - {b[W-1], b});
    trial = {rem_r[W-1:0], num_r[NW-1]} - {1'b0, mb_r};
    madd  = {1'b0, acc_r} + {1'b0, {FRAC_BITS{1'b0}}, mb_r};
    lim   = NW'({1'b0, {(W-1){1'b1}}}) + NW'(neg_r);
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    neg_nxt  = neg_r;
    mul_nxt  = mul_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    mb_nxt   = mb_r;
    res_nxt  = res_r;
    err_nxt  = err_r;
    if (start) begin
      err_nxt = ST_OK;
      neg_nxt = a[W-1] ^ b[W-1];
      case (op)
        OP_ADD, OP_SUB: begin
          done_nxt = 1'b1;
          res_nxt  = sum[W-1:0];
          if (sum[W] != sum[W-1]) begin
            err_nxt = ST_OVERFLOW;
            res_nxt = '0;
          end
        end
        OP_MUL: begin
          // Shift-add, multiplier bits taken LSB first; product accumulates
          // in acc with the final alignment applied at the end.
          busy_nxt = 1'b1;
          mul_nxt  = 1'b1;
          mb_nxt   = ma;
          num_nxt  = NW'(mbv);
          acc_nxt  = '0;
          rem_nxt  = '0;
          cnt_nxt  = CW'(W);
        end
        default: begin
          if (mbv == '0) begin
            done_nxt = 1'b1;
            err_nxt  = ST_DIV0;
            res_nxt  = '0;
          end else begin
            busy_nxt = 1'b1;
            mul_nxt  = 1'b0;
            mb_nxt   = mbv;
            num_nxt  = {ma, {FRAC_BITS{1'b0}}};
            acc_nxt  = '0;
            rem_nxt  = '0;
            cnt_nxt  = CW'(NW);
          end
        end
      endcase
    end else if (busy_r) begin
      if (cnt_r != '0) begin
        cnt_nxt = cnt_r - 1'b1;
        if (mul_r) begin
          // acc holds product high half, rem unused; num low half shifts out.
          if (num_r[0]) begin
            acc_nxt = madd[NW:1];
            num_nxt = {madd[0], num_r[NW-1:1]};
          end else begin
            acc_nxt = {1'b0, acc_r[NW-1:1]};
            num_nxt = {acc_r[0], num_r[NW-1:1]};
          end
        end else begin
          num_nxt = {num_r[NW-2:0], 1'b0};
          if (!trial[W]) begin
            rem_nxt = {1'b0, trial[W-1:0]};
            acc_nxt = {acc_r[NW-2:0], 1'b1};
          end else begin
            rem_nxt = {rem_r[W-1:0], num_r[NW-1]};
            acc_nxt = {acc_r[NW-2:0], 1'b0};
          end
        end
      end else begin
        logic [NW-1:0] mag;
        logic          hi_nz;
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        if (mul_r) begin
          // product = {acc, num[NW-1 -: W]} over 2W bits; drop FRAC_BITS.
          mag   = NW'({acc_r, num_r[NW-1 -: W]} >> FRAC_BITS);
          hi_nz = (({acc_r, num_r[NW-1 -: W]} >> FRAC_BITS) >> NW) != '0;
        end else begin
          mag   = acc_r;
          hi_nz = 1'b0;
        end
        if (hi_nz || mag > lim) begin
          err_nxt = ST_OVERFLOW;
          res_nxt = '0;
        end else begin
          err_nxt = ST_OK;
          res_nxt = neg_r ? W'(~mag + 1'b1) : mag[W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    neg_r <= neg_nxt;
    mul_r <= mul_nxt;
    cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    mb_r  <= mb_nxt;
    res_r <= res_nxt;
    err_r <= err_nxt;
  end

  assign busy = busy_r;
  assign done = done_r;
  assign res  = res_r;
  assign err  = err_r;
endmodule

### rtl/core/iee_datapath.sv
// ---------------------------------------------------------------------------
// iee_datapath
// Operand and operator stacks, number accumulator, error latch and ALU.
// ---------------------------------------------------------------------------
module iee_datapath #(
  parameter int STACK_DEPTH = 16,
  parameter int FRAC_BITS   = 16,
  parameter int VALUE_WIDTH = 48
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  iee_pkg::cmd_t          cmd,
  input  logic [3:0]             digit,
  output iee_pkg::stat_t         stat,
  output logic [VALUE_WIDTH-1:0] result
);
  import iee_pkg::*;

  localparam int W  = VALUE_WIDTH;
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [W-1:0] LIM = {1'b0, {(W-1){1'b1}}};

  logic [W-1:0] opd_r [STACK_DEPTH];
  op_t          opr_r [STACK_DEPTH];
  logic [CW-1:0] opd_cnt_r, opd_cnt_nxt, opr_cnt_r, opr_cnt_nxt;
  logic [W-1:0]  num_r, num_nxt;
  logic          seen_r, seen_nxt;
  status_t       err_r, err_nxt;
  logic [W-1:0]  a_r, b_r, res_r, res_nxt;

  logic           alu_busy, alu_done;
  logic [W-1:0]   alu_res;
  status_t        alu_err;
  logic [W-1:0]   inc, num10, push_val;
  logic           push_en, opd_full, opr_full;
  logic [AW-1:0]  push_idx;
  logic [W+3:0]   num10w;

  iee_alu #(.VALUE_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_alu (
    .clk(clk), .rst_n(rst_n), .start(cmd.start_reduce), .op(opr_r[AW'(opr_cnt_r)]),
    .a(a_r), .b(b_r), .busy(alu_busy), .done(alu_done), .res(alu_res), .err(alu_err)
  );

  assign opd_full = opd_cnt_r >= CW'(STACK_DEPTH);
  assign opr_full = opr_cnt_r >= CW'(STACK_DEPTH);

  always_comb begin
    inc    = W'(digit) << FRAC_BITS;
    num10w = ({4'd0, num_r} << 3) + ({4'd0, num_r} << 1) + {4'd0, inc};
    num10  = num10w[W-1:0];
  end

  function automatic status_t first_err(status_t cur, status_t nw);
    return (cur == ST_OK) ? nw : cur;
  endfunction

  always_comb begin
    opd_cnt_nxt = opd_cnt_r;
    opr_cnt_nxt = opr_cnt_r;
    num_nxt     = num_r;
    seen_nxt    = seen_r;
    err_nxt     = err_r;
    res_nxt     = res_r;
    push_en     = 1'b0;
    push_val    = num_r;
    push_idx    = AW'(opd_cnt_r);
    if (cmd.raise != ST_OK) err_nxt = first_err(err_nxt, status_t'(cmd.raise));
    if (cmd.acc_digit) begin
      if (num10w[W+3:W-1] != '0 || num_r > LIM) begin
        err_nxt = first_err(err_nxt, ST_OVERFLOW);
      end else begin
        num_nxt  = num10;
        seen_nxt = 1'b1;
      end
    end
    if (cmd.flush_num && seen_r) begin
      if (opd_full) err_nxt = first_err(err_nxt, ST_MALFORMED);
      else begin
        push_en     = 1'b1;
        opd_cnt_nxt = opd_cnt_r + 1'b1;
      end
      num_nxt  = '0;
      seen_nxt = 1'b0;
    end
    if (cmd.push_op) begin
      if (opr_full) err_nxt = first_err(err_nxt, ST_MALFORMED);
      else opr_cnt_nxt = opr_cnt_r + 1'b1;
    end
    if (cmd.pop_op) opr_cnt_nxt = opr_cnt_r - 1'b1;
    if (cmd.pop_opd && opd_cnt_r >= CW'(2)) opd_cnt_nxt = opd_cnt_r - CW'(2);
    if (cmd.commit_reduce) begin
      if (alu_err != ST_OK) err_nxt = first_err(err_nxt, alu_err);
      else begin
        push_en     = 1'b1;
        push_val    = alu_res;
        opd_cnt_nxt = opd_cnt_r + 1'b1;
      end
    end
    if (cmd.load_result) res_nxt = (err_r == ST_OK) ? opd_r[0] : '0;
    if (cmd.clear_all) begin
      opd_cnt_nxt = '0;
      opr_cnt_nxt = '0;
      num_nxt     = '0;
      seen_nxt    = 1'b0;
      err_nxt     = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      opd_cnt_r <= '0;
      opr_cnt_r <= '0;
      num_r     <= '0;
      seen_r    <= 1'b0;
      err_r     <= ST_OK;
    end else begin
      opd_cnt_r <= opd_cnt_nxt;
      opr_cnt_r <= opr_cnt_nxt;
      num_r     <= num_nxt;
      seen_r    <= seen_nxt;
      err_r     <= err_nxt;
    end
    if (push_en) opd_r[push_idx] <= push_val;
    if (cmd.push_op && !opr_full) opr_r[AW'(opr_cnt_r)] <= cmd.op_code;
    // Operands for a reduction are captured as they are popped.
    if (cmd.pop_opd) begin
      a_r <= opd_r[AW'(opd_cnt_r - CW'(2))];
      b_r <= opd_r[AW'(opd_cnt_r - CW'(1))];
    end
    res_r <= res_nxt;
  end

  always_comb begin
    stat.busy      = alu_busy;
    stat.opd_ge2   = opd_cnt_r >= CW'(2);
    stat.opd_is1   = opd_cnt_r == CW'(1);
    stat.opr_empty = opr_cnt_r == '0;
    stat.opr_full  = opr_full;
    stat.opd_full  = opd_full;
    stat.top_op    = opr_r[AW'(opr_cnt_r - 1'b1)];
    stat.err       = err_r;
  end

  assign result = res_r;
  // The ALU done pulse is unused; the controller's wait state watches busy instead.
  logic unused_done;
  assign unused_done = alu_done;
endmodule

### rtl/core/iee_ctrl.sv
// ---------------------------------------------------------------------------
// iee_ctrl
// Sequencer: token decode, reduction loop, end of expression and handshakes.
// ---------------------------------------------------------------------------
module iee_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic [7:0]     in_char,
  input  logic           in_last,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  iee_pkg::stat_t stat,
  output iee_pkg::cmd_t  cmd,
  output logic [3:0]     digit
);
  import iee_pkg::*;

  state_t     st_r, st_nxt;
  logic [7:0] ch_r, ch_nxt;
  logic       last_r, last_nxt;
  logic       fin_r, fin_nxt;    // reduction belongs to the final drain
  logic       rp_r, rp_nxt;      // reduction loop for a closing parenthesis
  op_t        op_r, op_nxt;
  logic       ov_r, ov_nxt;

  function automatic logic prio_hi(op_t o);
    return (o == OP_MUL) || (o == OP_DIV);
  endfunction

  // The digit value is taken from the held character, not the live input.
  assign digit = 4'(ch_r - CH_ZERO);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_IDLE;
      ov_r  <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      ov_r  <= ov_nxt;
    end
    ch_r   <= ch_nxt;
    last_r <= last_nxt;
    fin_r  <= fin_nxt;
    rp_r   <= rp_nxt;
    op_r   <= op_nxt;
  end

  always_comb begin
    logic err;
    err      = stat.err != ST_OK;
    st_nxt   = st_r;
    ch_nxt   = ch_r;
    last_nxt = last_r;
    fin_nxt  = fin_r;
    rp_nxt   = rp_r;
    op_nxt   = op_r;
    ov_nxt   = ov_r && !out_ready;
    cmd      = '0;
    cmd.op_code = op_r;
    in_ready = (st_r == S_IDLE) && !ov_r;
    out_valid = ov_r;
    case (st_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          ch_nxt   = in_char;
          last_nxt = in_last;
          fin_nxt  = 1'b0;
          st_nxt   = S_TOKEN;
        end
      end
      S_TOKEN: begin
        st_nxt  = last_r ? S_FIN_CHK : S_IDLE;
        fin_nxt = 1'b0;
        if (!err) begin
          if (ch_r inside {[CH_ZERO:CH_NINE]}) begin
            cmd.acc_digit = 1'b1;
          end else begin
            cmd.flush_num = 1'b1;
            rp_nxt = 1'b0;
            case (ch_r)
              CH_LP:  begin op_nxt = OP_LP;  st_nxt = S_PUSH_OP; end
              CH_RP:  begin op_nxt = OP_LP;  rp_nxt = 1'b1; st_nxt = S_RED_CHK; end
              CH_ADD: begin op_nxt = OP_ADD; st_nxt = S_RED_CHK; end
              CH_SUB: begin op_nxt = OP_SUB; st_nxt = S_RED_CHK; end
              CH_MUL: begin op_nxt = OP_MUL; st_nxt = S_RED_CHK; end
              CH_DIV: begin op_nxt = OP_DIV; st_nxt = S_RED_CHK; end
              default: begin
                cmd.raise = ST_MALFORMED;
                op_nxt = OP_LP;
              end
            endcase
          end
        end
      end
      S_RED_CHK: begin
        // Decide whether the top operator reduces now.
        if (err) st_nxt = (fin_r || last_r) ? S_FIN_CHK : S_IDLE;
        else if (fin_r) begin
          if (stat.opr_empty) st_nxt = S_FIN_CHK;
          else if (stat.top_op == OP_LP) begin
            cmd.raise = ST_MALFORMED;
            st_nxt = S_FIN_CHK;
          end else st_nxt = S_RED_POP;
        end else if (rp_r) begin
          if (stat.opr_empty) begin
            cmd.raise = ST_MALFORMED;
            st_nxt = last_r ? S_FIN_CHK : S_IDLE;
            fin_nxt = last_r;
          end else if (stat.top_op == OP_LP) begin
            cmd.pop_op = 1'b1;
            st_nxt = last_r ? S_RED_CHK : S_IDLE;
            fin_nxt = last_r;
          end else st_nxt = S_RED_POP;
        end else begin
          if (!stat.opr_empty && stat.top_op != OP_LP &&
              (prio_hi(stat.top_op) || !prio_hi(op_r))) st_nxt = S_RED_POP;
          else st_nxt = S_PUSH_OP;
        end
      end
      S_RED_POP: begin
        cmd.pop_op  = 1'b1;
        cmd.pop_opd = 1'b1;
        if (!stat.opd_ge2) begin
          cmd.raise = ST_MALFORMED;
          st_nxt = S_RED_DONE;
        end else st_nxt = S_RED_EXEC;
      end
      S_RED_EXEC: begin
        cmd.start_reduce = 1'b1;
        st_nxt = S_RED_WAIT;
      end
      S_RED_WAIT: begin
        if (!stat.busy) begin
          cmd.commit_reduce = 1'b1;
          st_nxt = S_RED_DONE;
        end
      end
      S_RED_DONE: begin
        if (err && !fin_r) st_nxt = last_r ? S_FIN_CHK : S_IDLE;
        else st_nxt = S_RED_CHK;
        if (err && !fin_r) fin_nxt = last_r;
      end
      S_PUSH_OP: begin
        if (!err) cmd.push_op = 1'b1;
        st_nxt   = last_r ? S_RED_CHK : S_IDLE;
        fin_nxt  = last_r;
      end
      S_FIN_CHK: begin
        if (!err && !fin_r) begin
          // A pending number is pushed before the final drain.
          cmd.flush_num = 1'b1;
          fin_nxt = 1'b1;
          st_nxt  = S_RED_CHK;
        end else begin
          if (!err && !stat.opd_is1) cmd.raise = ST_MALFORMED;
          st_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        cmd.load_result = 1'b1;
        st_nxt = S_OUT;
      end
      S_OUT: begin
        cmd.clear_all = 1'b1;
        ov_nxt = 1'b1;
        st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end
endmodule

### tb/tb.sv
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the infix expression evaluator. Characters are sent
// one word at a time; a behavioural two-stack evaluator predicts the value and
// status of each expression, and every result word is checked against it.
// ---------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import iee_pkg::*;

  localparam int VW = 48;
  localparam int FB = 16;
  localparam int DEPTH = 16;

  typedef struct {
    logic signed [VW-1:0] value;
    status_t              status;
  } outcome_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  iee_in_if in_ch ();
  iee_out_if #(.VALUE_WIDTH(VW)) out_ch ();

  infix_expression_evaluator_top dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  // Predictor state.
  longint     opd_stk[DEPTH];
  op_t        opr_stk[DEPTH];
  int         opd_n, opr_n;
  longint     num_acc;
  bit         num_seen;
  status_t    err_st;

  outcome_t   expected_results[$];
  int         mismatches;
  bit         quiet;   // no idling or back-pressure in the last part
  bit         rx_hold;

  function automatic void flag(status_t s);
    if (err_st == ST_OK) err_st = s;
  endfunction

  function automatic longint fit(logic signed [127:0] r);
    logic signed [127:0] lim;
    lim = 128'sd1 <<< (VW - 1);
    if (r >= lim || r < -lim) begin
      flag(ST_OVERFLOW);
      return 0;
    end
    return longint'(r);
  endfunction

  function automatic void opd_push(longint v);
    if (opd_n >= DEPTH) flag(ST_MALFORMED);
    else begin
      opd_stk[opd_n] = v;
      opd_n++;
    end
  endfunction

  function automatic void opr_push(op_t o);
    if (opr_n >= DEPTH) flag(ST_MALFORMED);
    else begin
      opr_stk[opr_n] = o;
      opr_n++;
    end
  endfunction

  function automatic void apply_top();
    op_t o;
    logic signed [127:0] a, b, r;
    longint v;
    opr_n--;
    o = opr_stk[opr_n];
    if (opd_n < 2) begin
      flag(ST_MALFORMED);
      return;
    end
    b = opd_stk[opd_n-1];
    a = opd_stk[opd_n-2];
    opd_n -= 2;
    // Signed division in SystemVerilog truncates toward zero, as required.
    case (o)
      OP_ADD: r = a + b;
      OP_SUB: r = a - b;
      OP_MUL: r = (a * b) / (128'sd1 <<< FB);
      default: begin
        if (b == 0) begin
          flag(ST_DIV0);
          return;
        end
        r = (a <<< FB) / b;
      end
    endcase
    v = fit(r);
    if (err_st == ST_OK) opd_push(v);
  endfunction

  function automatic int rank(op_t o);
    return (o == OP_MUL || o == OP_DIV) ? 2 : 1;
  endfunction

  function automatic void clear_eval();
    opd_n = 0; opr_n = 0; num_acc = 0; num_seen = 0; err_st = ST_OK;
  endfunction

  function automatic void eval_char(logic [7:0] c);
    op_t o;
    longint lim, inc;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      lim = (64'sd1 <<< (VW - 1)) - 1;
      inc = longint'(c - CH_ZERO) <<< FB;
      if (num_acc > (lim - inc) / 10) flag(ST_OVERFLOW);
      else begin
        num_acc = num_acc * 10 + inc;
        num_seen = 1;
      end
      return;
    end
    if (num_seen) begin
      opd_push(num_acc);
      num_acc = 0;
      num_seen = 0;
    end
    if (err_st != ST_OK) return;
    case (c)
      CH_LP: begin
        opr_push(OP_LP);
        return;
      end
      CH_RP: begin
        while (err_st == ST_OK && opr_n > 0 && opr_stk[opr_n-1] != OP_LP) apply_top();
        if (err_st != ST_OK) return;
        if (opr_n == 0) flag(ST_MALFORMED);
        else opr_n--;
        return;
      end
      CH_ADD: o = OP_ADD;
      CH_SUB: o = OP_SUB;
      CH_MUL: o = OP_MUL;
      CH_DIV: o = OP_DIV;
      default: begin
        flag(ST_MALFORMED);
        return;
      end
    endcase
    while (err_st == ST_OK && opr_n > 0 && opr_stk[opr_n-1] != OP_LP &&
           rank(opr_stk[opr_n-1]) >= rank(o))
      apply_top();
    if (err_st == ST_OK) opr_push(o);
  endfunction

  function automatic void predict_char(logic [7:0] c, bit last);
    outcome_t res;
    if (err_st == ST_OK) eval_char(c);
    if (!last) return;
    if (err_st == ST_OK) begin
      if (num_seen) opd_push(num_acc);
      while (err_st == ST_OK && opr_n > 0) begin
        if (opr_stk[opr_n-1] == OP_LP) flag(ST_MALFORMED);
        else apply_top();
      end
      if (err_st == ST_OK && opd_n != 1) flag(ST_MALFORMED);
    end
    res.value = (err_st == ST_OK) ? opd_stk[0][VW-1:0] : '0;
    res.status = err_st;
    expected_results.push_back(res);
    clear_eval();
  endfunction

  // Valid stays high after an accepted word; the next call replaces the word
  // in the same step unless it first idles, and drain() drops valid when the sender stops.
  task automatic send_char(logic [7:0] c, bit last);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.char_code <= c;
    in_ch.last_char <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_char(c, last);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Result checking and random back-pressure.
  always @(posedge clk) begin
    outcome_t e;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %0d", out_ch.value);
        end else begin
          e = expected_results.pop_front();
          if (out_ch.value !== e.value || out_ch.status !== e.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: value exp %0d got %0d, status exp %0d got %0d",
                       e.value, out_ch.value, e.status, out_ch.status);
          end
        end
      end
      if (!quiet && !rx_hold && $urandom_range(0, 4) == 0) begin
        rx_hold <= 1'b1;
        out_ch.ready <= 1'b0;
        fork
          begin
            repeat ($urandom_range(1, 7)) @(posedge clk);
            out_ch.ready <= 1'b1;
            rx_hold <= 1'b0;
          end
        join_none
      end
    end
  end

  function automatic string rand_number(int digits);
    string s;
    s = "";
    for (int i = 0; i < digits; i++) s = {s, string'(8'(CH_ZERO + $urandom_range(0, 9)))};
    return s;
  endfunction

  function automatic string rand_expr(int depth);
    string s;
    string ops;
    int n;
    ops = "+-*/";
    n = $urandom_range(1, 4);
    s = "";
    for (int i = 0; i < n; i++) begin
      if (i > 0) s = {s, string'(ops[$urandom_range(0, 3)])};
      if (depth > 0 && $urandom_range(0, 3) == 0) s = {s, "(", rand_expr(depth - 1), ")"};
      else s = {s, rand_number($urandom_range(1, 3))};
    end
    return s;
  endfunction

  task automatic test_directed();
    send_text("7");
    send_text("1+2*3");
    send_text("(1+2)*3");
    send_text("8-3-2");
    send_text("7/2");
    send_text("1/3*3");
    send_text("5/0");
    send_text("-4");
    send_text("2+");
    send_text("(1+2");
    send_text("1+2)");
    send_text("1 2");
    send_text("2147483647");
    send_text("2147483648");
    send_text("2147483647+1");
    send_text("65536*65536");
    send_text("0-2147483647-1");
    send_text("((((((((((((((((1))))))))))))))))");
    send_text("1+(1+(1+(1+(1+(1+(1+(1+(1+(1+(1+(1+(1+(1+(1+(1+1)))))))))))))))");
    send_text("(2)3");
    send_text("(");
    send_char(8'hFF, 1'b1);
    send_char(8'h00, 1'b1);
  endtask

  task automatic test_random(int items);
    int sent;
    string s;
    sent = 0;
    while (sent < items) begin
      if (sent > items * 4 / 5) quiet = 1;
      if ($urandom_range(0, 9) == 0) begin
        // random noise bytes, mostly illegal characters
        s = "";
        repeat ($urandom_range(1, 6)) s = {s, string'(8'($urandom_range(0, 255)))};
      end else s = rand_expr(3);
      if ($urandom_range(0, 15) == 0) s = {s, ")"};
      send_text(s);
      sent += s.len();
      if ($urandom_range(0, 40) == 0) drain();
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.char_code = '0;
    in_ch.last_char = 1'b0;
    out_ch.ready = 1'b1;
    rx_hold = 0;
    quiet = 0;
    mismatches = 0;
    clear_eval();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    drain();
    test_random(1250);
    drain();
    repeat (200) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end
endmodule
